// ----- rtl/frmg_pkg.sv -----
// Package for the frame-rate multiplier governor: sizes, limits, register codes and types.
`default_nettype none

package frmg_pkg;

  // Ring and datapath sizes
  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int COUNT_W    = $clog2(RING_DEPTH + 1);
  localparam int RATE_W     = 16;
  localparam int SUM_W      = $clog2(RING_DEPTH * ((1 << RATE_W) - 1) + 1);
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int MULT_W     = 3;
  localparam int USER_W     = 4;
  localparam int FRAMES_W   = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Rate limits in 1/16 frames per second
  localparam logic [RATE_W-1:0] RATE_LOW_LIMIT  = 16'd320;
  localparam logic [RATE_W-1:0] RATE_MID_LIMIT  = 16'd640;
  localparam logic [RATE_W-1:0] RATE_HIGH_LIMIT = 16'd1120;
  localparam logic [COUNT_W-1:0] MIN_HISTORY    = COUNT_W'(3);

  // Multiplier codes and bounds
  localparam logic [MULT_W-1:0] MULT_TWO   = 3'd2;
  localparam logic [MULT_W-1:0] MULT_THREE = 3'd3;
  localparam logic [MULT_W-1:0] MULT_FOUR  = 3'd4;
  localparam logic [FRAMES_W-1:0] FRAMES_MAX = 3'd7;

  // Register reset values
  localparam logic [RATE_W-1:0] THRESHOLD_RESET = 16'd1920;
  localparam logic [USER_W-1:0] USER_MULT_RESET = 4'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_ENABLE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_OFF_ENABLE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_OFF_THRESHOLD = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USER_MULTIPLIER    = 8'd3;

  // Channel payloads
  typedef struct packed {
    logic [RATE_W-1:0] rate_sample;
  } in_item_t;

  typedef struct packed {
    logic                decision_valid;
    logic [RATE_W-1:0]   rolling_average;
    logic [MULT_W-1:0]   adaptive_multiplier;
    logic                forced_off;
    logic [FRAMES_W-1:0] frames_to_generate;
    logic                settings_changed;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_step;
    logic decide;
    logic no_decision;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic go;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/frmg_if.sv -----
// Channel interfaces of the governor: sample input, result output and register writes.
`default_nettype none

interface frmg_in_if;
  logic               valid;
  logic               ready;
  frmg_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface frmg_out_if;
  logic                valid;
  logic                ready;
  frmg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface frmg_cfg_if;
  logic                valid;
  logic                ready;
  frmg_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/frmg_div.sv -----
// Restoring serial divider: one quotient bit per step, sum over fill count.
`default_nettype none

module frmg_div (
  input  wire logic                         clk,
  input  wire logic                         start,
  input  wire logic                         step,
  input  wire logic [frmg_pkg::SUM_W-1:0]   dividend,
  input  wire logic [frmg_pkg::COUNT_W-1:0] divisor,
  output logic      [frmg_pkg::SUM_W-1:0]   quotient
);

  logic [frmg_pkg::COUNT_W-1:0] rem_r;
  logic [frmg_pkg::COUNT_W-1:0] rem_nxt;
  logic [frmg_pkg::SUM_W-1:0]   quo_r;
  logic [frmg_pkg::SUM_W-1:0]   quo_nxt;
  logic [frmg_pkg::COUNT_W:0]   trial;
  logic [frmg_pkg::COUNT_W:0]   diff;
  logic                         fits;

  // Shift in the next dividend bit and try one subtraction
  always_comb begin
    trial   = {rem_r, quo_r[frmg_pkg::SUM_W-1]};
    diff    = trial - {1'b0, divisor};
    fits    = (trial >= {1'b0, divisor});
    rem_nxt = fits ? diff[frmg_pkg::COUNT_W-1:0] : trial[frmg_pkg::COUNT_W-1:0];
    quo_nxt = {quo_r[frmg_pkg::SUM_W-2:0], fits};
  end

  // Load on start, advance one bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/frmg_dpath.sv -----
// Governor datapath: registers, sample ring, running sum, divider, decision and result register.
`default_nettype none

module frmg_dpath (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire frmg_pkg::ctrl_cmd_t    cmd,
  output frmg_pkg::dp_status_t        status,
  input  wire frmg_pkg::in_item_t     in_data,
  input  wire logic                   cfg_valid,
  input  wire frmg_pkg::cfg_item_t    cfg_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output frmg_pkg::out_item_t         out_data
);

  // Configuration registers
  logic                            adaptive_r;
  logic                            auto_off_r;
  logic [frmg_pkg::RATE_W-1:0]     threshold_r;
  logic [frmg_pkg::USER_W-1:0]     user_mult_r;

  // Ring memory and its bookkeeping
  logic [frmg_pkg::RATE_W-1:0]     ring_mem [frmg_pkg::RING_DEPTH];
  logic [frmg_pkg::RATE_W-1:0]     rd_data_r;
  logic [frmg_pkg::SLOT_W-1:0]     slot_r;
  logic [frmg_pkg::COUNT_W-1:0]    count_r;
  logic [frmg_pkg::SUM_W-1:0]      sum_r;
  logic [frmg_pkg::RATE_W-1:0]     sample_r;
  logic [frmg_pkg::RATE_W-1:0]     oldest;
  logic                            ring_full;

  // Decision state
  logic [frmg_pkg::MULT_W-1:0]     chosen_r;
  logic                            off_r;
  logic                            dec_valid_r;
  logic [frmg_pkg::RATE_W-1:0]     mean_r;
  logic                            changed_r;

  // Divider and decision logic
  logic [frmg_pkg::SUM_W-1:0]      quotient;
  logic [frmg_pkg::RATE_W-1:0]     mean;
  logic [frmg_pkg::MULT_W-1:0]     pick;
  logic                            want_off;
  logic [frmg_pkg::USER_W-1:0]     effective;
  logic [frmg_pkg::USER_W-1:0]     eff_less;
  logic [frmg_pkg::FRAMES_W-1:0]   frames;

  // Result register
  logic                            out_valid_r;
  frmg_pkg::out_item_t             out_data_r;

  // Take register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adaptive_r  <= 1'b0;
      auto_off_r  <= 1'b0;
      threshold_r <= frmg_pkg::THRESHOLD_RESET;
      user_mult_r <= frmg_pkg::USER_MULT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_data.reg_index)
        frmg_pkg::REG_ADAPTIVE_ENABLE:    adaptive_r  <= cfg_data.wdata[0];
        frmg_pkg::REG_AUTO_OFF_ENABLE:    auto_off_r  <= cfg_data.wdata[0];
        frmg_pkg::REG_AUTO_OFF_THRESHOLD: threshold_r <= cfg_data.wdata[frmg_pkg::RATE_W-1:0];
        frmg_pkg::REG_USER_MULTIPLIER:    user_mult_r <= cfg_data.wdata[frmg_pkg::USER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read the slot about to be overwritten; write the new sample on update
  always_ff @(posedge clk) begin
    rd_data_r <= ring_mem[slot_r];
    if (cmd.update) begin
      ring_mem[slot_r] <= sample_r;
    end
  end

  // Entries beyond the fill count were never written and count as zero
  assign ring_full = (count_r == frmg_pkg::COUNT_W'(frmg_pkg::RING_DEPTH));
  assign oldest    = ring_full ? rd_data_r : '0;

  // Hold the sample; advance slot, count and sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else if (cmd.update) begin
      sum_r <= sum_r - frmg_pkg::SUM_W'(oldest) + frmg_pkg::SUM_W'(sample_r);
      if (slot_r == frmg_pkg::SLOT_W'(frmg_pkg::RING_DEPTH - 1)) begin
        slot_r <= '0;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
      if (!ring_full) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_data.rate_sample;
    end
  end

  frmg_div u_div (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (sum_r),
    .divisor  (count_r),
    .quotient (quotient)
  );

  // Map the mean to a multiplier and test the threshold
  always_comb begin
    mean = quotient[frmg_pkg::RATE_W-1:0];
    if (mean <= frmg_pkg::RATE_LOW_LIMIT) begin
      pick = frmg_pkg::MULT_FOUR;
    end else if (mean <= frmg_pkg::RATE_MID_LIMIT) begin
      pick = frmg_pkg::MULT_THREE;
    end else if (mean <= frmg_pkg::RATE_HIGH_LIMIT) begin
      pick = frmg_pkg::MULT_TWO;
    end else if (user_mult_r < frmg_pkg::USER_W'(frmg_pkg::MULT_TWO)) begin
      pick = frmg_pkg::MULT_TWO;
    end else if (user_mult_r > frmg_pkg::USER_W'(frmg_pkg::MULT_FOUR)) begin
      pick = frmg_pkg::MULT_FOUR;
    end else begin
      pick = user_mult_r[frmg_pkg::MULT_W-1:0];
    end
    want_off = auto_off_r && (mean > threshold_r);
  end

  // Record the decision, or clear it when none is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chosen_r    <= '0;
      off_r       <= 1'b0;
      dec_valid_r <= 1'b0;
      mean_r      <= '0;
      changed_r   <= 1'b0;
    end else if (cmd.decide) begin
      chosen_r    <= pick;
      off_r       <= want_off;
      dec_valid_r <= 1'b1;
      mean_r      <= mean;
      changed_r   <= (pick != chosen_r) || (want_off != off_r);
    end else if (cmd.no_decision) begin
      dec_valid_r <= 1'b0;
      mean_r      <= '0;
      changed_r   <= 1'b0;
    end
  end

  // Effective multiplier less one, saturated to the field
  always_comb begin
    if (adaptive_r && (chosen_r >= frmg_pkg::MULT_TWO)) begin
      effective = frmg_pkg::USER_W'(chosen_r);
    end else begin
      effective = user_mult_r;
    end
    eff_less = effective - 1'b1;
    if (effective == '0) begin
      frames = '0;
    end else if (eff_less > frmg_pkg::USER_W'(frmg_pkg::FRAMES_MAX)) begin
      frames = frmg_pkg::FRAMES_MAX;
    end else begin
      frames = eff_less[frmg_pkg::FRAMES_W-1:0];
    end
  end

  // Result register: load a new beat, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.decision_valid      <= dec_valid_r;
      out_data_r.rolling_average     <= mean_r;
      out_data_r.adaptive_multiplier <= chosen_r;
      out_data_r.forced_off          <= off_r;
      out_data_r.frames_to_generate  <= frames;
      out_data_r.settings_changed    <= changed_r;
    end
  end

  assign status.go       = adaptive_r && (count_r >= frmg_pkg::MIN_HISTORY);
  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/frmg_ctrl.sv -----
// Governor controller: sequences capture, ring update, division, decision and result load.
`default_nettype none

module frmg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire frmg_pkg::dp_status_t status,
  output frmg_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CHECK,
    ST_DIVIDE,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [frmg_pkg::STEP_W-1:0] step_r;
  logic [frmg_pkg::STEP_W-1:0] step_nxt;
  logic                        last_step;

  assign last_step = (step_r == frmg_pkg::STEP_W'(frmg_pkg::SUM_W - 1));

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.go) begin
          cmd.div_start = 1'b1;
          step_nxt      = '0;
          state_nxt     = ST_DIVIDE;
        end else begin
          cmd.no_decision = 1'b1;
          state_nxt       = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (last_step) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/frame_rate_multiplier_governor.sv -----
// Frame-rate multiplier governor: one rate sample in, one decision result out.
// Flow: capture, ring update, then division and decision when one is taken, result load.
// Throughput: set by the serial divider, one quotient bit a cycle; no new sample is taken
//   before the result of the last one is loaded into the output register.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_n low, synchronous) clears ring fill count, sum, decision and registers
//   to their defaults at once; no clearing pass is needed.
`default_nettype none

module frame_rate_multiplier_governor (
  input  wire logic  clk,
  input  wire logic  rst_n,
  frmg_in_if.sink    in_ch,
  frmg_out_if.source out_ch,
  frmg_cfg_if.sink   cfg_ch
);

  frmg_pkg::ctrl_cmd_t  cmd;
  frmg_pkg::dp_status_t status;
  logic                 in_ready;

  // Register writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  frmg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  frmg_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_ch.data),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

`default_nettype wire
